@@ rtl/core/encoder_button_event_qualifier_unit_macros.svh @@
// Assertion macros shared by the event qualifier RTL.
// Each macro checks one implication on the rising clock edge, with the
// check switched off while the synchronous active-low reset is asserted.
`ifndef ENCODER_BUTTON_EVENT_QUALIFIER_UNIT_MACROS_SVH
`define ENCODER_BUTTON_EVENT_QUALIFIER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define EBQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ebq assertion failed");
// Next-cycle implication.
`define EBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ebq assertion failed");
`else
`define EBQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/ebq_pkg.sv @@
`default_nettype none

package ebq_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned PosW      = 32;
    localparam int unsigned BtnDbW    = 10;
    localparam int unsigned LongW     = 16;
    localparam int unsigned EncDbW    = 10;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned EventW    = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_BTN_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ENC_DEBOUNCE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BtnDbW-1:0] BTN_DEBOUNCE_RST = 10'd50;
    localparam logic [LongW-1:0]  LONG_PRESS_RST   = 16'd1000;
    localparam logic [EncDbW-1:0] ENC_DEBOUNCE_RST = 10'd5;

    // Item kinds.
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    typedef enum logic [EventW-1:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_PRESS = 3'd3,
        EV_LONG  = 3'd4
    } t_event;

    typedef struct packed {
        logic [BtnDbW-1:0] btn_settle_ms;
        logic [LongW-1:0]  long_press_ms;
        logic [EncDbW-1:0] enc_gap_ms;
    } t_cfg;

    // Rotation status handed from the encoder tracker to the result select.
    typedef struct packed {
        logic pending;
        logic ccw;
    } t_rot;

endpackage

`default_nettype wire

@@ rtl/core/ebq_encoder.sv @@
`default_nettype none
`include "encoder_button_event_qualifier_unit_macros.svh"

module ebq_encoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_edge,
    input  wire logic                          i_poll,
    input  wire logic [ebq_pkg::TimeW-1:0]     i_now_ms,
    input  wire logic                          i_enc_data_level,
    input  wire logic [ebq_pkg::EncDbW-1:0]    i_enc_debounce_ms,
    output ebq_pkg::t_rot                      o_rot
);

    logic [ebq_pkg::PosW-1:0]  r_position;
    logic [ebq_pkg::PosW-1:0]  r_reported;
    logic [ebq_pkg::TimeW-1:0] r_last_edge;
    logic [ebq_pkg::TimeW-1:0] since_edge;
    logic [ebq_pkg::PosW-1:0]  diff;
    logic                      edge_go;

    assign since_edge = i_now_ms - r_last_edge;
    assign edge_go    = i_edge && (since_edge >= ebq_pkg::TimeW'(i_enc_debounce_ms));
    assign diff       = r_position - r_reported;

    // Sign of the wrapped difference picks the direction.
    assign o_rot.pending = (r_position != r_reported);
    assign o_rot.ccw     = diff[ebq_pkg::PosW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_reported  <= '0;
            r_last_edge <= '0;
        end else begin
            if (edge_go) begin
                r_last_edge <= i_now_ms;
                if (i_enc_data_level) begin
                    r_position <= r_position + 1'b1;
                end else begin
                    r_position <= r_position - 1'b1;
                end
            end
            if (i_poll && o_rot.pending) begin
                r_reported <= r_position;
            end
        end
    end

    `EBQ_ASSERT_NEXT(a_edge_moves, i_clk, i_rst_n, edge_go, r_position != $past(r_position))
    `EBQ_ASSERT_NEXT(a_edge_ignored, i_clk, i_rst_n, i_edge && !edge_go, $stable(r_position))
    `EBQ_ASSERT_NEXT(a_poll_consumes, i_clk, i_rst_n, i_poll, r_reported == $past(r_position))

endmodule

`default_nettype wire

@@ rtl/core/ebq_button.sv @@
`default_nettype none
`include "encoder_button_event_qualifier_unit_macros.svh"

module ebq_button (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_poll,
    input  wire logic [ebq_pkg::TimeW-1:0]     i_now_ms,
    input  wire logic                          i_button_pin,
    input  wire logic [ebq_pkg::BtnDbW-1:0]    i_btn_debounce_ms,
    input  wire logic [ebq_pkg::LongW-1:0]     i_long_press_ms,
    output ebq_pkg::t_event                    o_event
);

    logic [ebq_pkg::TimeW-1:0] r_level_change;
    logic [ebq_pkg::TimeW-1:0] r_press_start;
    logic                      r_last_raw;
    logic                      r_stable;
    logic                      r_consumed;

    logic                      raw;
    logic                      level_moved;
    logic [ebq_pkg::TimeW-1:0] level_time;
    logic                      settled;
    logic                      flip;
    logic                      went_down;
    logic                      stable_now;
    logic                      consumed_now;
    logic [ebq_pkg::TimeW-1:0] start_now;
    logic                      fire_press;
    logic                      fire_long;

    // The pin is active low.
    assign raw         = !i_button_pin;
    assign level_moved = (raw != r_last_raw);
    assign level_time  = level_moved ? i_now_ms : r_level_change;
    assign settled     = (i_now_ms - level_time) > ebq_pkg::TimeW'(i_btn_debounce_ms);
    assign flip        = settled && (raw != r_stable);
    assign went_down   = flip && raw;

    // State as seen after a possible debounced level change in this poll.
    assign stable_now   = flip ? raw : r_stable;
    assign consumed_now = went_down ? 1'b0 : r_consumed;
    assign start_now    = went_down ? i_now_ms : r_press_start;

    assign fire_press = flip && !raw && !r_consumed;
    assign fire_long  = settled && !fire_press && stable_now && !consumed_now
                        && ((i_now_ms - start_now) >= ebq_pkg::TimeW'(i_long_press_ms));

    always_comb begin
        if (fire_press) begin
            o_event = ebq_pkg::EV_PRESS;
        end else if (fire_long) begin
            o_event = ebq_pkg::EV_LONG;
        end else begin
            o_event = ebq_pkg::EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_change <= '0;
            r_press_start  <= '0;
            r_last_raw     <= 1'b0;
            r_stable       <= 1'b0;
            r_consumed     <= 1'b0;
        end else if (i_poll) begin
            r_level_change <= level_time;
            r_press_start  <= start_now;
            r_stable       <= stable_now;
            r_consumed     <= consumed_now || fire_long;
            // A reported press or long press leaves the raw level as it was.
            if (!fire_press && !fire_long) begin
                r_last_raw <= raw;
            end
        end
    end

    `EBQ_ASSERT_NEXT(a_long_marks, i_clk, i_rst_n, i_poll && fire_long, r_consumed)
    `EBQ_ASSERT_NEXT(a_level_time, i_clk, i_rst_n, i_poll && level_moved,
                     r_level_change == $past(i_now_ms))
    `EBQ_ASSERT_NOW(a_one_event, i_clk, i_rst_n, 1'b1, !(fire_press && fire_long))

endmodule

`default_nettype wire

@@ rtl/core/encoder_button_event_qualifier_unit.sv @@
`default_nettype none
`include "encoder_button_event_qualifier_unit_macros.svh"
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_action, i_now_ms, i_enc_data_level,
//                                                 i_button_pin
// result    out        o_out_valid / i_out_stall  o_event_res
// config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One beat is accepted per clock unless o_in_stall is high; each input beat gives
// exactly one result beat. The path is an input register, then the qualifier logic
// into the result register. Rate is set by one compare-and-update pass.
// Reset (i_rst_n low, synchronous) empties both registers, clears all tracking
// state and loads the configuration defaults.
// A stall on the result side holds both stages; the input side stalls only when
// its register is full and cannot move on.

module encoder_button_event_qualifier_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [ebq_pkg::TimeW-1:0]     i_now_ms,
    input  wire logic                          i_enc_data_level,
    input  wire logic                          i_button_pin,
    // Result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ebq_pkg::EventW-1:0]         o_event_res,
    // Configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [ebq_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [ebq_pkg::CfgDataW-1:0]  i_cfg_data
);

    // Configuration registers.
    ebq_pkg::t_cfg r_cfg;

    // Input register.
    logic                      r_in_valid;
    logic                      r_action;
    logic [ebq_pkg::TimeW-1:0] r_now_ms;
    logic                      r_enc_data_level;
    logic                      r_button_pin;

    // Result register.
    logic                      r_out_valid;
    ebq_pkg::t_event           r_event;

    logic                      advance;
    logic                      process;
    logic                      is_edge;
    logic                      is_poll;
    ebq_pkg::t_rot             rot;
    ebq_pkg::t_event           btn_event;
    ebq_pkg::t_event           n_event;

    // The result register can take a new beat when it is empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign process    = r_in_valid && advance;
    assign is_edge    = process && (r_action == ebq_pkg::ACT_EDGE);
    assign is_poll    = process && (r_action == ebq_pkg::ACT_POLL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btn_settle_ms <= ebq_pkg::BTN_DEBOUNCE_RST;
            r_cfg.long_press_ms <= ebq_pkg::LONG_PRESS_RST;
            r_cfg.enc_gap_ms    <= ebq_pkg::ENC_DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ebq_pkg::CFG_BTN_DEBOUNCE: begin
                    r_cfg.btn_settle_ms <= i_cfg_data[ebq_pkg::BtnDbW-1:0];
                end
                ebq_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_press_ms <= i_cfg_data[ebq_pkg::LongW-1:0];
                end
                ebq_pkg::CFG_ENC_DEBOUNCE: begin
                    r_cfg.enc_gap_ms <= i_cfg_data[ebq_pkg::EncDbW-1:0];
                end
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Input register: filled on an accepted beat, emptied when the result stage moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action         <= i_action;
            r_now_ms         <= i_now_ms;
            r_enc_data_level <= i_enc_data_level;
            r_button_pin     <= i_button_pin;
        end
    end

    ebq_encoder u_encoder (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_edge            (is_edge),
        .i_poll            (is_poll),
        .i_now_ms          (r_now_ms),
        .i_enc_data_level  (r_enc_data_level),
        .i_enc_debounce_ms (r_cfg.enc_gap_ms),
        .o_rot             (rot)
    );

    // A poll that reports a rotation does not look at the button at all.
    ebq_button u_button (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_poll            (is_poll && !rot.pending),
        .i_now_ms          (r_now_ms),
        .i_button_pin      (r_button_pin),
        .i_btn_debounce_ms (r_cfg.btn_settle_ms),
        .i_long_press_ms   (r_cfg.long_press_ms),
        .o_event           (btn_event)
    );

    // Encoder edges always report nothing; a poll reports rotation first.
    always_comb begin
        if (r_action == ebq_pkg::ACT_EDGE) begin
            n_event = ebq_pkg::EV_NONE;
        end else if (rot.pending) begin
            n_event = rot.ccw ? ebq_pkg::EV_CCW : ebq_pkg::EV_CW;
        end else begin
            n_event = btn_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_event <= n_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

    `EBQ_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    `EBQ_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, process, r_out_valid)
    `EBQ_ASSERT_NEXT(a_edge_silent, i_clk, i_rst_n, is_edge, r_event == ebq_pkg::EV_NONE)

endmodule

`default_nettype wire
